>>> rtl/core/stue_pkg.sv
// ----------------------------------------------------------------------------
// Sprite table update engine package
// Shared types, codes and constants for the sprite table update engine.
// ----------------------------------------------------------------------------
package stue_pkg;

  localparam int NUM_SPRITES = 128;
  localparam int ID_W = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
  localparam logic [8:0] ID_LIMIT = 9'(NUM_SPRITES);

  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 56;
  localparam int DISP_W = 20;

  localparam logic [10:0] SCREEN_WIDTH_RESET = 11'd320;
  localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd240;

  // Configuration register indexes.
  localparam logic REG_SCREEN_WIDTH = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Request modes.
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_HIDE = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_NO_IMAGE = 2'd2;

  localparam logic [7:0] KEEP_CODE = 8'h80;
  localparam logic [7:0] KEEP_POS_HI = 8'h80;
  localparam logic [5:0] EDGE_SMALL = 6'd16;
  localparam logic [5:0] EDGE_LARGE = 6'd32;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_DRAW   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [7:0]  code;
    logic [7:0]  flip;
    logic [5:0]  edge_len;
    logic [15:0] source;
    logic        drawn;
    logic        visible;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    left: 16'hFFFF, top: 16'hFFFF, code: 8'h00, flip: 8'h00,
    edge_len: 6'd0, source: 16'h0000, drawn: 1'b0, visible: 1'b0
  };

  // Decisions taken for one request.
  typedef struct packed {
    logic       wr_en;
    logic       clear_all;
    logic       do_erase;
    logic       do_draw;
    logic       do_tail;
    cmd_t       tail_cmd;
    logic [1:0] tail_status;
  } upd_t;

endpackage

>>> rtl/core/stue_table.sv
// ----------------------------------------------------------------------------
// Sprite table store
// One synchronous memory of sprite entries with per-entry valid bits. An entry
// that is not valid reads as the reset entry, so a table clear needs no pass over the memory.
// ----------------------------------------------------------------------------
module stue_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [stue_pkg::ID_W-1:0] rd_addr,
  output stue_pkg::entry_t         rd_entry,
  input  logic                     wr_en,
  input  logic [stue_pkg::ID_W-1:0] wr_addr,
  input  stue_pkg::entry_t         wr_entry,
  input  logic                     clear_all
);

  stue_pkg::entry_t mem [stue_pkg::NUM_SPRITES];
  stue_pkg::entry_t rdata;
  logic [stue_pkg::NUM_SPRITES-1:0] valid;
  logic rd_valid;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (clear_all) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_entry = rd_valid ? rdata : stue_pkg::ENTRY_RESET;

endmodule

>>> rtl/core/stue_update.sv
// ----------------------------------------------------------------------------
// Sprite update decision
// Compares a request with the stored entry, builds the new entry and decides
// which erase, draw and status results the request produces.
// ----------------------------------------------------------------------------
module stue_update (
  input  logic [1:0]       mode,
  input  logic [7:0]       sprite_id,
  input  logic [15:0]      x_centre,
  input  logic [15:0]      y_centre,
  input  logic [7:0]       image_code,
  input  logic [7:0]       flip_code,
  input  logic [15:0]      image_offset,
  input  logic             image_found,
  input  logic [10:0]      screen_width,
  input  logic [10:0]      screen_height,
  input  stue_pkg::entry_t old_entry,
  output stue_pkg::entry_t new_entry,
  output stue_pkg::upd_t   ctl
);

  logic bad_id;
  logic xy_ch;
  logic im_ch;
  logic fl_ch;
  logic [5:0] edge_sel;
  logic [15:0] half;
  logic [15:0] left_new;
  logic [15:0] top_new;
  logic signed [17:0] room_x;
  logic signed [17:0] room_y;
  logic fits;

  assign bad_id = {1'b0, sprite_id} >= stue_pkg::ID_LIMIT;
  assign xy_ch = (x_centre[15:8] != stue_pkg::KEEP_POS_HI) &&
                 ((old_entry.left != x_centre) || (old_entry.top != y_centre));
  assign im_ch = (image_code != stue_pkg::KEEP_CODE) && (image_code != old_entry.code);
  assign fl_ch = (flip_code != stue_pkg::KEEP_CODE) && (flip_code != old_entry.flip);

  assign edge_sel = !im_ch ? old_entry.edge_len :
                    (image_code[6] ? stue_pkg::EDGE_LARGE : stue_pkg::EDGE_SMALL);
  assign half = {11'd0, edge_sel[5:1]};
  assign left_new = x_centre - half;
  assign top_new = y_centre - half;

  // The corner must stay strictly below the screen size minus the edge.
  assign room_x = $signed({7'd0, screen_width}) - $signed({12'd0, edge_sel});
  assign room_y = $signed({7'd0, screen_height}) - $signed({12'd0, edge_sel});
  assign fits = !left_new[15] && !top_new[15] &&
                ($signed({2'b00, left_new}) < room_x) &&
                ($signed({2'b00, top_new}) < room_y);

  always_comb begin
    new_entry = old_entry;
    ctl = '0;
    ctl.tail_cmd = stue_pkg::CMD_STATUS;
    ctl.tail_status = stue_pkg::ST_OK;
    if (mode == stue_pkg::MODE_RESET) begin
      ctl.clear_all = 1'b1;
      ctl.tail_cmd = stue_pkg::CMD_CLEAR;
    end else if (mode == stue_pkg::MODE_NONE) begin
      ctl.tail_status = stue_pkg::ST_OK;
    end else if (bad_id) begin
      ctl.tail_status = stue_pkg::ST_BAD_ID;
    end else if (mode == stue_pkg::MODE_HIDE) begin
      ctl.wr_en = 1'b1;
      ctl.do_erase = old_entry.drawn;
      new_entry.drawn = 1'b0;
      new_entry.visible = 1'b0;
    end else if (xy_ch || im_ch || fl_ch) begin
      ctl.wr_en = 1'b1;
      ctl.do_erase = old_entry.drawn;
      new_entry.drawn = 1'b0;
      new_entry.visible = 1'b1;
      new_entry.edge_len = edge_sel;
      if (fl_ch) begin
        new_entry.flip = flip_code;
      end
      if (im_ch) begin
        new_entry.code = image_code;
        if (image_found) begin
          new_entry.source = image_offset;
        end else begin
          ctl.tail_status = stue_pkg::ST_NO_IMAGE;
        end
      end
      // A failed image lookup leaves the sprite undrawn and unmoved.
      if (!im_ch || image_found) begin
        if (xy_ch) begin
          new_entry.left = left_new;
          new_entry.top = top_new;
          new_entry.visible = fits;
        end
        if (new_entry.visible) begin
          ctl.do_draw = 1'b1;
          new_entry.drawn = 1'b1;
        end
      end
    end
    ctl.do_tail = (!ctl.do_erase && !ctl.do_draw) || (ctl.tail_status != stue_pkg::ST_OK);
  end

endmodule

>>> rtl/core/sprite_table_update_engine.sv
// ----------------------------------------------------------------------------
// Sprite table update engine
// Keeps the sprite table and turns update, hide and reset requests into
// erase, draw, clear and status commands for a sprite layer renderer.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel, one at a time. Each request yields one or
// two results on the m_ channel; m_tlast marks the final one. Results carry
// the command in m_tuser and the sprite's buffer offset, source, edge, flip
// and status in m_tdata. Screen width and height are written on the cfg_
// channel (index 0 width, index 1 height). The user must write them only
// while no request is in flight; the block itself does not enforce this.
// A request passes from the accept state to the table read (S_LOOK), which
// uses the registered memory output, then the offset multipliers (S_MUL),
// then one output state per result loaded into the output register.
// The table memory has a single read and a single write port; the write-back
// happens before the next request is read, so no forwarding is needed.
// Reset, and a reset request, clear the table at once through per-entry valid
// bits; no clearing pass runs. A stalled receiver holds the output register
// and the sequencer waits, so s_tready stays low until the last result of the
// current request has been loaded.
// ----------------------------------------------------------------------------
module sprite_table_update_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sprite_id[7:0], x_centre[23:8], y_centre[39:24], image_code[47:40],
  // flip_code[55:48], image_offset[71:56], image_found[72], zero[79:73]
  input  logic [79:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // display_offset[19:0], source_offset[35:20], sprite_size[41:36],
  // flip_bits[49:42], status[51:50], zero[55:52]
  output logic [55:0] m_tdata,
  // command[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MUL,
    S_ERASE,
    S_DRAW,
    S_TAIL
  } state_t;

  state_t state;

  logic [10:0] screen_width;
  logic [10:0] screen_height;

  logic [1:0]  it_mode;
  logic [7:0]  it_id;
  logic [15:0] it_x;
  logic [15:0] it_y;
  logic [7:0]  it_code;
  logic [7:0]  it_flip;
  logic [15:0] it_img;
  logic        it_found;

  stue_pkg::entry_t rd_entry;
  stue_pkg::entry_t upd_entry;
  stue_pkg::upd_t   upd_ctl;
  stue_pkg::entry_t old_e;
  stue_pkg::entry_t new_e;
  stue_pkg::upd_t   ctl;

  logic        in_acc;
  logic        out_free;
  logic        out_load;
  logic        tbl_wr;
  logic        tbl_clear;

  logic [19:0] top_old_x;
  logic [19:0] top_new_x;
  logic [19:0] prod_old_full;
  logic [19:0] prod_new_full;
  logic [19:0] prod_old;
  logic [19:0] prod_new;
  logic [19:0] disp_old;
  logic [19:0] disp_new;

  assign in_acc = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free &&
                    ((state == S_ERASE) || (state == S_DRAW) || (state == S_TAIL));
  assign tbl_wr = (state == S_LOOK) && upd_ctl.wr_en;
  assign tbl_clear = (state == S_LOOK) && upd_ctl.clear_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= stue_pkg::SCREEN_WIDTH_RESET;
      screen_height <= stue_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == stue_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end else begin
        screen_height <= cfg_data;
      end
    end
  end

  stue_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_acc),
    .rd_addr   (s_tdata[stue_pkg::ID_W-1:0]),
    .rd_entry  (rd_entry),
    .wr_en     (tbl_wr),
    .wr_addr   (it_id[stue_pkg::ID_W-1:0]),
    .wr_entry  (upd_entry),
    .clear_all (tbl_clear)
  );

  stue_update u_update (
    .mode          (it_mode),
    .sprite_id     (it_id),
    .x_centre      (it_x),
    .y_centre      (it_y),
    .image_code    (it_code),
    .flip_code     (it_flip),
    .image_offset  (it_img),
    .image_found   (it_found),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .old_entry     (rd_entry),
    .new_entry     (upd_entry),
    .ctl           (upd_ctl)
  );

  // Offsets are taken modulo 2**20 with the corner treated as signed.
  assign top_old_x = {{4{old_e.top[15]}}, old_e.top};
  assign top_new_x = {{4{new_e.top[15]}}, new_e.top};
  assign prod_old_full = top_old_x * {9'd0, screen_width};
  assign prod_new_full = top_new_x * {9'd0, screen_width};
  assign disp_old = {{4{old_e.left[15]}}, old_e.left} + prod_old;
  assign disp_new = {{4{new_e.left[15]}}, new_e.left} + prod_new;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      it_mode <= s_tuser;
      it_id <= s_tdata[7:0];
      it_x <= s_tdata[23:8];
      it_y <= s_tdata[39:24];
      it_code <= s_tdata[47:40];
      it_flip <= s_tdata[55:48];
      it_img <= s_tdata[71:56];
      it_found <= s_tdata[72];
    end
    if (state == S_LOOK) begin
      old_e <= rd_entry;
      new_e <= upd_entry;
      ctl <= upd_ctl;
    end
    if (state == S_MUL) begin
      prod_old <= prod_old_full;
      prod_new <= prod_new_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (ctl.do_erase) begin
            state <= S_ERASE;
          end else if (ctl.do_draw) begin
            state <= S_DRAW;
          end else begin
            state <= S_TAIL;
          end
        end
        S_ERASE: begin
          if (out_free) begin
            m_tuser <= stue_pkg::CMD_ERASE;
            m_tdata <= {4'd0, stue_pkg::ST_OK, old_e.flip, old_e.edge_len,
                        old_e.source, disp_old};
            m_tlast <= !ctl.do_draw && !ctl.do_tail;
            if (ctl.do_draw) begin
              state <= S_DRAW;
            end else if (ctl.do_tail) begin
              state <= S_TAIL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DRAW: begin
          if (out_free) begin
            m_tuser <= stue_pkg::CMD_DRAW;
            m_tdata <= {4'd0, stue_pkg::ST_OK, new_e.flip, new_e.edge_len,
                        new_e.source, disp_new};
            m_tlast <= !ctl.do_tail;
            state <= ctl.do_tail ? S_TAIL : S_IDLE;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            m_tuser <= ctl.tail_cmd;
            m_tdata <= {4'd0, ctl.tail_status, 50'd0};
            m_tlast <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A request holds the sequencer until its last result is loaded.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another was in flight");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == stue_pkg::CMD_CLEAR)) |-> (m_tdata == '0))
    else $error("clear command carries payload");

  a_sprite_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser == stue_pkg::CMD_ERASE) || (m_tuser == stue_pkg::CMD_DRAW)))
      |-> (m_tdata[51:50] == stue_pkg::ST_OK))
    else $error("erase or draw carries an error status");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[51:50] != stue_pkg::ST_OK)) |-> m_tlast)
    else $error("error status on a result that is not last");

endmodule
